### design/row_peak_finder_top_assert.svh
// ----------------------------------------------------------------------------
// Row peak finder assertion macros
// Concurrent checks on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ROW_PEAK_FINDER_TOP_ASSERT_SVH
`define ROW_PEAK_FINDER_TOP_ASSERT_SVH
`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define RPF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// antecedent implies consequent in the next cycle
`define RPF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RPF_ASSERT_IMP(lbl, ante, cons, msg)
`define RPF_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### design/rpf_pkg.sv
// ----------------------------------------------------------------------------
// rpf_pkg
// Shared constants and types of the row peak finder.
// ----------------------------------------------------------------------------
`default_nettype none
package rpf_pkg;

  localparam int ROW_DEPTH   = 2048;
  localparam int MAX_PEAKS   = 32;
  localparam int SAMPLE_BITS = 16;

  localparam int PW = $clog2(ROW_DEPTH);        // position width
  localparam int CW = $clog2(ROW_DEPTH + 1);    // sample count width
  localparam int EW = $clog2(MAX_PEAKS + 1);    // emitted count width

  localparam int IDX_W  = 11;
  localparam int WID_W  = 11;
  localparam int PROM_W = 16;
  localparam int OUTQ_DEPTH = 4;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic [15:0] min_height;
    logic [11:0] min_width;
    logic [15:0] min_prominence;
    logic [11:0] min_separation;
  } cfg_t;

  typedef struct packed {
    logic          en;
    logic [PW-1:0] addr;
    sample_t       data;
  } mem_wr_t;

  typedef struct packed {
    logic [CW-1:0] count;
    logic          trunc;
  } job_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [WID_W-1:0]  wid;
    logic [PROM_W-1:0] prom;
    logic              none;
    logic              ovf;
    logic              fin;
  } result_t;

endpackage
`default_nettype wire

### design/rpf_loader.sv
// ----------------------------------------------------------------------------
// rpf_loader
// Front end: writes row samples into the row memory, hands a row job on.
// ----------------------------------------------------------------------------
`default_nettype none
module rpf_loader (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [15:0]      s_tdata,
  input  wire logic             s_tlast,
  input  wire logic             scan_busy,
  input  wire logic             job_take,
  output rpf_pkg::mem_wr_t      wr,
  output rpf_pkg::job_t         job,
  output logic                  job_valid
);

  logic [rpf_pkg::CW-1:0] count;
  logic                   trunc;
  logic                   accept;
  logic                   full;

  assign s_tready = !job_valid && !scan_busy;
  assign accept   = s_tvalid && s_tready;
  assign full     = (count == rpf_pkg::CW'(rpf_pkg::ROW_DEPTH));

  assign wr.en   = accept && !full;
  assign wr.addr = count[rpf_pkg::PW-1:0];
  assign wr.data = s_tdata[rpf_pkg::SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      trunc     <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      if (job_take) begin
        job_valid <= 1'b0;
      end
      if (accept) begin
        if (s_tlast) begin
          job_valid <= 1'b1;
          job.count <= full ? count : count + rpf_pkg::CW'(1);
          job.trunc <= trunc || full;
          count     <= '0;
          trunc     <= 1'b0;
        end else if (full) begin
          trunc <= 1'b1;
        end else begin
          count <= count + rpf_pkg::CW'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

### design/rpf_scanner.sv
// ----------------------------------------------------------------------------
// rpf_scanner
// Back end: row memory and the sequencer that scans, walks and qualifies.
// ----------------------------------------------------------------------------
`default_nettype none
module rpf_scanner (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire rpf_pkg::cfg_t    cfg,
  input  wire rpf_pkg::mem_wr_t wr,
  input  wire rpf_pkg::job_t    job,
  input  wire logic             job_valid,
  output logic                  job_take,
  output logic                  busy,
  input  wire logic             out_full,
  output logic                  out_push,
  output rpf_pkg::result_t      out_data
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOAD0  = 4'd1;
  localparam logic [3:0] S_LOAD1  = 4'd2;
  localparam logic [3:0] S_LOAD2  = 4'd3;
  localparam logic [3:0] S_CHECK  = 4'd4;
  localparam logic [3:0] S_LREQ   = 4'd5;
  localparam logic [3:0] S_LCMP   = 4'd6;
  localparam logic [3:0] S_RREQ   = 4'd7;
  localparam logic [3:0] S_RCMP   = 4'd8;
  localparam logic [3:0] S_EVAL   = 4'd9;
  localparam logic [3:0] S_RESUME = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  rpf_pkg::sample_t mem [rpf_pkg::ROW_DEPTH];
  rpf_pkg::sample_t rdata;
  logic [rpf_pkg::PW-1:0] rd_addr;

  logic [3:0]             state;
  logic [rpf_pkg::PW-1:0] last_pos, i, p, q, last_acc;
  rpf_pkg::sample_t       prev, cur, nxt, above, below;
  logic                   any, dropped, pend_v;
  logic [rpf_pkg::EW-1:0] emitted;
  rpf_pkg::result_t       pend;

  logic                   cand, at_end, ok, room, stall;
  logic [rpf_pkg::PW-1:0] wid, sep;
  rpf_pkg::sample_t       valley, prom;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[rd_addr];
  end

  assign busy     = (state != S_IDLE);
  assign job_take = (state == S_IDLE) && job_valid;

  assign cand   = (cur > cfg.min_height) && (cur > prev) && (cur >= rdata);
  assign at_end = ((i + rpf_pkg::PW'(1)) == last_pos);
  assign wid    = q - p;
  assign valley = (above > below) ? above : below;
  assign prom   = cur - valley;
  assign sep    = i - last_acc;
  assign ok     = ({1'b0, wid} >= cfg.min_width) && (prom > cfg.min_prominence) &&
                  (!any || ({1'b0, sep} > cfg.min_separation));
  assign room   = (emitted < rpf_pkg::EW'(rpf_pkg::MAX_PEAKS));
  assign stall  = ok && room && pend_v && out_full;

  always_comb begin
    rd_addr  = '0;
    out_push = 1'b0;
    out_data = pend;
    unique case (state)
      S_LOAD0:  rd_addr = '0;
      S_LOAD1:  rd_addr = rpf_pkg::PW'(1);
      S_LOAD2:  rd_addr = rpf_pkg::PW'(2);
      S_CHECK:  rd_addr = i + rpf_pkg::PW'(2);
      S_LREQ:   rd_addr = p - rpf_pkg::PW'(1);
      S_RREQ:   rd_addr = q + rpf_pkg::PW'(1);
      S_RESUME: rd_addr = i + rpf_pkg::PW'(1);
      S_EVAL: begin
        out_push = ok && room && pend_v && !out_full;
      end
      S_FIN: begin
        out_push = !out_full;
        if (pend_v) begin
          out_data.fin = 1'b1;
          out_data.ovf = dropped;
        end else begin
          out_data = '{idx: '0, wid: '0, prom: '0, none: 1'b1, ovf: dropped, fin: 1'b1};
        end
      end
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            last_pos <= rpf_pkg::PW'(job.count - rpf_pkg::CW'(1));
            dropped  <= job.trunc;
            i        <= rpf_pkg::PW'(1);
            any      <= 1'b0;
            emitted  <= '0;
            pend_v   <= 1'b0;
            state    <= (job.count < rpf_pkg::CW'(3)) ? S_FIN : S_LOAD0;
          end
        end
        S_LOAD0: state <= S_LOAD1;
        S_LOAD1: begin
          prev  <= rdata;
          state <= S_LOAD2;
        end
        S_LOAD2: begin
          cur   <= rdata;
          state <= S_CHECK;
        end
        S_CHECK: begin
          nxt <= rdata;
          if (cand) begin
            p     <= i - rpf_pkg::PW'(1);
            above <= prev;
            q     <= i + rpf_pkg::PW'(1);
            below <= rdata;
            state <= S_LREQ;
          end else if (at_end) begin
            state <= S_FIN;
          end else begin
            i    <= i + rpf_pkg::PW'(1);
            prev <= cur;
            cur  <= rdata;
          end
        end
        S_LREQ: state <= (p == '0) ? S_RREQ : S_LCMP;
        S_LCMP: begin
          if (rdata <= above) begin
            p     <= p - rpf_pkg::PW'(1);
            above <= rdata;
            state <= S_LREQ;
          end else begin
            state <= S_RREQ;
          end
        end
        S_RREQ: state <= (q == last_pos) ? S_EVAL : S_RCMP;
        S_RCMP: begin
          if (rdata <= below) begin
            q     <= q + rpf_pkg::PW'(1);
            below <= rdata;
            state <= S_RREQ;
          end else begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (!stall) begin
            if (ok) begin
              any      <= 1'b1;
              last_acc <= i;
              if (room) begin
                emitted <= emitted + rpf_pkg::EW'(1);
                pend_v  <= 1'b1;
                pend    <= '{idx: rpf_pkg::IDX_W'(i), wid: rpf_pkg::WID_W'(wid),
                             prom: rpf_pkg::PROM_W'(prom), none: 1'b0, ovf: 1'b0,
                             fin: 1'b0};
              end else begin
                dropped <= 1'b1;
              end
            end
            if (at_end) begin
              state <= S_FIN;
            end else begin
              i     <= i + rpf_pkg::PW'(1);
              prev  <= cur;
              cur   <= nxt;
              state <= S_RESUME;
            end
          end
        end
        S_RESUME: state <= S_CHECK;
        S_FIN: begin
          if (!out_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### design/rpf_out_queue.sv
// ----------------------------------------------------------------------------
// rpf_out_queue
// Small result queue in front of the master stream port.
// ----------------------------------------------------------------------------
`default_nettype none
module rpf_out_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire rpf_pkg::result_t din,
  output logic                  full,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output rpf_pkg::result_t      dout
);

  localparam int AW = $clog2(rpf_pkg::OUTQ_DEPTH);

  rpf_pkg::result_t q [rpf_pkg::OUTQ_DEPTH];
  logic [AW-1:0]    wptr, rptr;
  logic [AW:0]      cnt;
  logic             pop;

  assign full     = (cnt == (AW+1)'(rpf_pkg::OUTQ_DEPTH));
  assign m_tvalid = (cnt != '0);
  assign pop      = m_tvalid && m_tready;
  assign dout     = q[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      q[wptr] <= din;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push && !full) begin
        wptr <= wptr + AW'(1);
      end
      if (pop) begin
        rptr <= rptr + AW'(1);
      end
      cnt <= cnt + (AW+1)'(push && !full) - (AW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

### design/row_peak_finder_top.sv
// Results: a row with fewer than three samples skips the scan for its final result, a
//   longer row gets it at the end of the scan; a peak result waits for the next emitted
//   peak or the scan end. Samples load one beat per cycle while s_tready is high.
// Scan: each position passes S_CHECK; a candidate then walks S_LREQ/S_LCMP and
//   S_RREQ/S_RCMP to S_EVAL over the single memory read port; a full queue adds stalls.
// Input stalls from the row's last beat until its final result is queued.
// Reset: rst synchronous, control and config registers reset; row memory not cleared.
// ----------------------------------------------------------------------------
// row_peak_finder_top
// Stream front end, row memory scanner and result queue with an APB register port.
// ----------------------------------------------------------------------------
`default_nettype none
module row_peak_finder_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // APB register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // sample stream in
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [15:0] sample
  input  wire logic        s_tlast,   // row_end
  // result stream out
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [10:0] peak_index, [21:11] peak_width,
                                      // [37:22] peak_prominence, [39:38] zero
  output logic [1:0]       m_tuser,   // [0] none_found, [1] overflow
  output logic             m_tlast    // final_result
);

  localparam logic [1:0] REG_HEIGHT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_PROM   = 2'd2;
  localparam logic [1:0] REG_SEP    = 2'd3;

  rpf_pkg::cfg_t    cfg;
  rpf_pkg::mem_wr_t wr;
  rpf_pkg::job_t    job;
  rpf_pkg::result_t res, qout;
  logic             job_valid, job_take, scan_busy, res_push, q_full;
  logic             wr_en;

  // Registers: written on the access phase of an APB write.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_height     <= 16'd0;
      cfg.min_width      <= 12'd0;
      cfg.min_prominence <= 16'd0;
      cfg.min_separation <= 12'd100;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_HEIGHT: cfg.min_height     <= pwdata[15:0];
        REG_WIDTH:  cfg.min_width      <= pwdata[11:0];
        REG_PROM:   cfg.min_prominence <= pwdata[15:0];
        REG_SEP:    cfg.min_separation <= pwdata[11:0];
        default:    cfg.min_height     <= cfg.min_height;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_HEIGHT: prdata = {16'd0, cfg.min_height};
      REG_WIDTH:  prdata = {20'd0, cfg.min_width};
      REG_PROM:   prdata = {16'd0, cfg.min_prominence};
      REG_SEP:    prdata = {20'd0, cfg.min_separation};
      default:    prdata = '0;
    endcase
  end

  // Front: store each beat, hand the finished row over as a job.
  rpf_loader u_loader (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .scan_busy, .job_take, .wr, .job, .job_valid
  );

  // Back: scan the stored row and qualify peaks.
  rpf_scanner u_scanner (
    .clk, .rst, .cfg, .wr, .job, .job_valid, .job_take,
    .busy(scan_busy), .out_full(q_full), .out_push(res_push), .out_data(res)
  );

  // Results wait here so the scan never holds on a slow consumer mid-walk.
  rpf_out_queue u_outq (
    .clk, .rst, .push(res_push), .din(res), .full(q_full),
    .m_tvalid, .m_tready, .dout(qout)
  );

  assign m_tdata = {2'b00, qout.prom, qout.wid, qout.idx};
  assign m_tuser = {qout.ovf, qout.none};
  assign m_tlast = qout.fin;

`include "row_peak_finder_top_assert.svh"

  `RPF_ASSERT_IMP(a_no_load_during_scan, s_tready, !scan_busy && !job_valid, "beat taken during scan")
  `RPF_ASSERT_IMP(a_no_push_when_full, res_push, !q_full, "result pushed into full queue")
  `RPF_ASSERT_NXT(a_take_starts_scan, job_take, scan_busy, "job taken but scan not started")

endmodule
`default_nettype wire
